>>> src/pos_pkg.sv
// Package for the priority opportunity scheduler: command, status and state codes.
// No dependencies.
package pos_pkg;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_PICK    = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NO_PICK = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REFILL,
      ST_POP_READ,
      ST_POP_DONE
   } state_type;

endpackage

>>> src/pos_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/priority_opportunity_scheduler_top.sv
// Top level of the priority opportunity scheduler.
// Depends on pos_pkg and pos_ram (thread id store).
//
//   channel  | handshake        | beat fields
//   request  | start / busy     | req_cmd, req_thread_id, req_priority_req
//   response | rsp_valid strobe | rsp_status, rsp_has_thread, rsp_picked_thread
//
// An enqueue never raises busy, and its response strobe comes in the cycle after the
// accepting edge; so does the response to a pick when no level exists yet.
// Any other pick holds busy while it scans one level per cycle, then walks the levels
// again when opportunities are refilled, then reads the store (ST_POP_READ, ST_POP_DONE);
// its response strobe rises in the same cycle that busy falls.
// Reset is synchronous and clears all per-level counters; the thread store holds
// no reset value. The response is a one-cycle strobe; the receiver cannot stall.
module priority_opportunity_scheduler_top
   import pos_pkg::*;
#(
   parameter int NUM_LEVELS = 16,
   parameter int FIFO_DEPTH = 16,
   parameter int ID_BITS    = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_cmd,
   input  logic [7:0] req_thread_id,
   input  logic [3:0] req_priority_req,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic       rsp_has_thread,
   output logic [7:0] rsp_picked_thread
);

   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int SW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int OW = $clog2(NUM_LEVELS + 1);
   localparam int AW = $clog2(NUM_LEVELS * FIFO_DEPTH);

   logic [NUM_LEVELS-1:0] exists_ff, exists_in;
   logic [OW-1:0] chances_ff [NUM_LEVELS];
   logic [OW-1:0] chances_in [NUM_LEVELS];
   logic [SW-1:0] head_ff [NUM_LEVELS];
   logic [SW-1:0] head_in [NUM_LEVELS];
   logic [CW-1:0] count_ff [NUM_LEVELS];
   logic [CW-1:0] count_in [NUM_LEVELS];
   logic [LW-1:0] cur_ff, cur_in;
   logic          cur_valid_ff, cur_valid_in;
   state_type     state_ff, state_in;
   logic [LW-1:0] scan_ff, scan_in;     // level under test
   logic          wrap_ff, wrap_in;     // scan wrapped past the top
   logic [OW-1:0] rank_ff, rank_in;
   logic [LW-1:0] first_ff, first_in;   // lowest existing level
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_has_ff, rsp_has_in;
   logic [7:0]    rsp_thread_ff, rsp_thread_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [ID_BITS-1:0] rd_data;
   logic [SW-1:0]   slot;
   logic [SW:0]     slot_sum;
   logic [LW-1:0]   req_lv;
   logic            req_lv_ok;
   logic            ready_lv;
   logic            scan_last;

   pos_ram #(.WIDTH(ID_BITS), .DEPTH(NUM_LEVELS * FIFO_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_thread_id[ID_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_lv    = LW'(req_priority_req);
   assign req_lv_ok = 32'(req_priority_req) < NUM_LEVELS;
   assign slot_sum  = (SW+1)'(head_ff[req_lv]) + (SW+1)'(count_ff[req_lv]);
   assign slot      = (slot_sum >= (SW+1)'(FIFO_DEPTH)) ?
                      SW'(slot_sum - (SW+1)'(FIFO_DEPTH)) : SW'(slot_sum);
   assign ready_lv  = exists_ff[scan_ff] && chances_ff[scan_ff] != '0
                      && count_ff[scan_ff] != '0
                      && !(cur_valid_ff && scan_ff == cur_ff);
   assign scan_last = 32'(scan_ff) == NUM_LEVELS - 1;
   assign rd_addr   = AW'(32'(cur_ff) * FIFO_DEPTH + 32'(head_ff[cur_ff]));
   assign wr_addr   = AW'(32'(req_lv) * FIFO_DEPTH + 32'(slot));

   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_has_thread    = rsp_has_ff;
   assign rsp_picked_thread = rsp_thread_ff;

   always_comb begin
      exists_in     = exists_ff;
      chances_in    = chances_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      state_in      = state_ff;
      scan_in       = scan_ff;
      wrap_in       = wrap_ff;
      rank_in       = rank_ff;
      first_in      = first_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_has_in    = 1'b0;
      rsp_thread_in = '0;
      wr_en         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  if (!req_lv_ok || 32'(count_ff[req_lv]) >= FIFO_DEPTH) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     exists_in[req_lv]  = 1'b1;
                     count_in[req_lv]   = count_ff[req_lv] + CW'(1);
                  end
               end else if (exists_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NO_PICK;
               end else begin
                  state_in = ST_SCAN;
                  if (cur_valid_ff && 32'(cur_ff) != NUM_LEVELS - 1) begin
                     scan_in = cur_ff + LW'(1);
                     wrap_in = 1'b0;
                  end else begin
                     scan_in = '0;
                     wrap_in = 1'b1;
                  end
               end
            end
         end
         ST_SCAN: begin
            // The second pass stops at the current level, or at the top level if none is current.
            if (ready_lv) begin
               cur_in       = scan_ff;
               cur_valid_in = 1'b1;
               state_in     = ST_POP_READ;
            end else if (scan_last || (wrap_ff && cur_valid_ff && scan_ff == cur_ff)) begin
               if (wrap_ff) begin
                  state_in = ST_REFILL;
                  scan_in  = '0;
                  rank_in  = OW'(1);
               end else begin
                  scan_in = '0;
                  wrap_in = 1'b1;
               end
            end else begin
               scan_in = scan_ff + LW'(1);
            end
         end
         ST_REFILL: begin
            if (exists_ff[scan_ff]) begin
               chances_in[scan_ff] = rank_ff;
               rank_in             = rank_ff + OW'(1);
               if (rank_ff == OW'(1)) begin
                  first_in = scan_ff;
               end
            end
            if (scan_last) begin
               cur_in       = (exists_ff[scan_ff] && rank_ff == OW'(1)) ? scan_ff : first_ff;
               cur_valid_in = 1'b1;
               state_in     = ST_POP_READ;
            end else begin
               scan_in = scan_ff + LW'(1);
            end
         end
         ST_POP_READ: begin
            // The store read of the head entry is in flight this cycle.
            if (chances_ff[cur_ff] != '0) begin
               chances_in[cur_ff] = chances_ff[cur_ff] - OW'(1);
            end
            state_in = ST_POP_DONE;
         end
         ST_POP_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (count_ff[cur_ff] == '0) begin
               rsp_status_in = STATUS_NO_PICK;
            end else begin
               rsp_has_in     = 1'b1;
               rsp_thread_in  = 8'(rd_data);
               count_in[cur_ff] = count_ff[cur_ff] - CW'(1);
               head_in[cur_ff]  = (32'(head_ff[cur_ff]) == FIFO_DEPTH - 1) ?
                                  '0 : head_ff[cur_ff] + SW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exists_ff    <= '0;
         chances_ff   <= '{default: '0};
         head_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         exists_ff    <= exists_in;
         chances_ff   <= chances_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      wrap_ff       <= wrap_in;
      rank_ff       <= rank_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_thread_ff <= rsp_thread_in;
   end

endmodule

>>> dv/pos_checker.sv
// Checker for the priority opportunity scheduler: watches request and response beats,
// predicts each response with its own scheduler model and compares. Depends on pos_pkg.
`timescale 1ns / 1ps
module pos_checker
   import pos_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic       req_cmd,
   input  logic [7:0] req_thread_id,
   input  logic [3:0] req_priority_req,
   input  logic       rsp_valid,
   input  logic [1:0] rsp_status,
   input  logic       rsp_has_thread,
   input  logic [7:0] rsp_picked_thread,
   output int         fail_count,
   output int         pending_count,
   output int         pick_hits,
   output int         full_hits
);
   localparam int LEVELS = 16;
   localparam int DEPTH  = 16;

   typedef struct packed {
      logic [1:0] status;
      logic       has_thread;
      logic [7:0] picked;
   } sched_rsp_type;

   logic        lvl_exists [LEVELS];
   logic [4:0]  lvl_chances[LEVELS];
   logic [7:0]  lvl_store  [LEVELS][DEPTH];
   logic [3:0]  lvl_head   [LEVELS];
   logic [4:0]  lvl_count  [LEVELS];
   logic [3:0]  cur_level;
   logic        cur_valid;
   sched_rsp_type expected_rsps[$];

   function automatic logic level_ready(int lv);
      return lvl_exists[lv] && lvl_chances[lv] != 0 && lvl_count[lv] != 0;
   endfunction

   function automatic int select_level();
      int rank;
      int first;
      first = cur_valid ? int'(cur_level) + 1 : 0;
      for (int lv = first; lv < LEVELS; lv++)
         if (level_ready(lv)) return lv;
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (cur_valid && lv == cur_level) continue;
         if (level_ready(lv)) return lv;
      end
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (lvl_exists[lv]) begin
            rank = 1;
            for (int k = 0; k < LEVELS; k++) begin
               if (lvl_exists[k]) begin
                  lvl_chances[k] = rank[4:0];
                  rank++;
               end
            end
            return lv;
         end
      end
      return -1;
   endfunction

   function automatic sched_rsp_type schedule_beat(logic cmd, logic [7:0] id, logic [3:0] lvl);
      sched_rsp_type r;
      int lv;
      r = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (lvl_count[lvl] >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            lvl_exists[lvl] = 1'b1;
            lvl_store[lvl][lvl_head[lvl] + lvl_count[lvl][3:0]] = id;
            lvl_count[lvl]++;
         end
      end else begin
         lv = select_level();
         if (lv < 0) begin
            r.status = STATUS_NO_PICK;
         end else begin
            if (lvl_chances[lv] != 0) lvl_chances[lv]--;
            cur_level = lv[3:0];
            cur_valid = 1'b1;
            if (lvl_count[lv] == 0) begin
               r.status = STATUS_NO_PICK;
            end else begin
               r.picked = lvl_store[lv][lvl_head[lv]];
               r.has_thread = 1'b1;
               lvl_head[lv]++;
               lvl_count[lv]--;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      sched_rsp_type want;
      if (reset) begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            lvl_exists[lv] = 1'b0;
            lvl_chances[lv] = '0;
            lvl_head[lv] = '0;
            lvl_count[lv] = '0;
         end
         cur_level = '0;
         cur_valid = 1'b0;
         expected_rsps.delete();
      end else begin
         // Response first: a response cannot belong to a request taken this edge.
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_has_thread !== want.has_thread)
                  report_mismatch($sformatf("has_thread %0b, expected %0b",
                                            rsp_has_thread, want.has_thread));
               if (rsp_picked_thread !== want.picked)
                  report_mismatch($sformatf("picked_thread %0d, expected %0d",
                                            rsp_picked_thread, want.picked));
            end
         end
         if (start && !busy) begin
            want = schedule_beat(req_cmd, req_thread_id, req_priority_req);
            if (want.has_thread) pick_hits++;
            if (want.status == STATUS_FULL) full_hits++;
            expected_rsps.push_back(want);
         end
      end
   end

   initial begin
      fail_count = 0;
      pick_hits = 0;
      full_hits = 0;
   end
endmodule

>>> dv/tb_priority_opportunity_scheduler_top.sv
// Testbench top for the priority opportunity scheduler: clock, reset, directed and
// random command beats, verdict. Depends on pos_pkg, pos_checker and the block.
`timescale 1ns / 1ps
module tb_priority_opportunity_scheduler_top;
   import pos_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_cmd = CMD_ENQUEUE;
   logic [7:0] req_thread_id = '0;
   logic [3:0] req_priority_req = '0;
   logic       rsp_valid;
   logic [1:0] rsp_status;
   logic       rsp_has_thread;
   logic [7:0] rsp_picked_thread;
   int         fail_count, pending_count, pick_hits, full_hits;
   int         beats_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   priority_opportunity_scheduler_top dut (.*);

   pos_checker u_checker (.*);

   // Issues one command beat and holds it until the block takes it.
   task automatic send_beat(logic cmd, logic [7:0] id, logic [3:0] lvl);
      start <= 1'b1;
      req_cmd <= cmd;
      req_thread_id <= id;
      req_priority_req <= lvl;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      idle_cycles(1);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int burst;
      int mode;
      beats_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pick with no level, fill one level to overflow, extreme ids and levels.
      send_beat(CMD_PICK, 8'hFF, 4'hF);
      for (int i = 0; i < 17; i++) send_beat(CMD_ENQUEUE, (i == 0) ? 8'h00 : 8'hA5 ^ i[7:0], 4'd15);
      send_beat(CMD_ENQUEUE, 8'hFF, 4'd0);
      send_beat(CMD_PICK, 8'h00, 4'd0);
      send_beat(CMD_PICK, 8'h00, 4'd0);
      send_beat(CMD_PICK, 8'h00, 4'd0);
      send_beat(CMD_PICK, 8'h00, 4'd0);
      drain();

      // Random: mostly enqueues and picks on a few levels, so levels run dry and refill.
      while (beats_sent < 1600) begin
         burst = $urandom_range(1, 20);
         mode = $urandom_range(0, 3);
         for (int i = 0; i < burst; i++) begin
            if ($urandom_range(0, 99) < ((mode == 0) ? 75 : (mode == 1) ? 25 : 50))
               send_beat(CMD_ENQUEUE, 8'($urandom),
                         (mode == 3) ? 4'($urandom) : 4'($urandom_range(0, 5) * 3));
            else
               send_beat(CMD_PICK, 8'($urandom), 4'($urandom));
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 4));
         end
         if ($urandom_range(0, 9) == 0) drain();
         else idle_cycles($urandom_range(0, 30));
      end

      drain();
      repeat (60) @(posedge clock);
      $display("Sent %0d command beats: %0d picks returned a thread, %0d enqueues refused.",
               beats_sent, pick_hits, full_hits);
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5ms;
      $display("Run timed out.");
      $display("*** FAILED ***");
      $finish;
   end
endmodule
